### rtl/core/ilte_pkg.sv
// Shared constants, codes and types for the indexed list table engine.
package ilte_pkg;

    localparam int CAPACITY = 64;
    localparam int ELEM_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;

    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [6:0]       NONE_POS = 7'h7F;

    // request codes
    localparam logic [3:0] FN_PUSH    = 4'd0;
    localparam logic [3:0] FN_POP     = 4'd1;
    localparam logic [3:0] FN_READ    = 4'd2;
    localparam logic [3:0] FN_WRITE   = 4'd3;
    localparam logic [3:0] FN_INSERT  = 4'd4;
    localparam logic [3:0] FN_DELETE  = 4'd5;
    localparam logic [3:0] FN_DELRNG  = 4'd6;
    localparam logic [3:0] FN_DELVAL  = 4'd7;
    localparam logic [3:0] FN_SEARCH  = 4'd8;
    localparam logic [3:0] FN_EXTEND  = 4'd9;
    localparam logic [3:0] FN_CLEAR   = 4'd10;

    // status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_FULL     = 3'd1;
    localparam logic [2:0] STS_EMPTY    = 3'd2;
    localparam logic [2:0] STS_RANGE    = 3'd3;
    localparam logic [2:0] STS_NOTFOUND = 3'd4;

    // broadcast cell operations
    localparam logic [2:0] CELL_HOLD   = 3'd0;
    localparam logic [2:0] CELL_PUT    = 3'd1;
    localparam logic [2:0] CELL_INSERT = 3'd2;
    localparam logic [2:0] CELL_REMOVE = 3'd3;
    localparam logic [2:0] CELL_FILL   = 3'd4;
    localparam logic [2:0] CELL_CMP    = 3'd5;

    typedef struct packed {
        logic [2:0]        op;
        logic [CNT_W-1:0]  pos;
        logic [CNT_W-1:0]  lim;
        logic [ELEM_W-1:0] value;
    } t_cell_cmd;

endpackage

### rtl/core/indexed_list_table_engine.sv
// Top level of the indexed list table engine: request decode, cell chain, result register.
// Timing: push, pop, read, write, insert, delete, extend and clear load the result register
//   in the cycle after the input transfer; search and delete value first register a compare
//   in every cell, then load the highest-match encode into the result register; a range
//   delete removes last - first + 1 slots, one single-slot downward shift of the chain per cycle.
// Throughput: one request per cycle while results are taken, but not during a search or range delete.
// Reset (i_rst_n low, synchronous): count, state and result valid cleared; cell contents are not cleared.
module indexed_list_table_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [6:0] position, [12:7] range_last, [19:13] new_length,
    // [51:20] operand_value, [55:52] zero
    input  logic [55:0] s_axis_tdata,
    // [3:0] func
    input  logic [3:0]  s_axis_tuser,
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] data_out, [38:32] match_position, [45:39] length_now,
    // [48:46] status, [55:49] zero
    output logic [55:0] m_axis_tdata
);

    localparam int ELEM_W = ilte_pkg::ELEM_W;
    localparam int IDX_W  = ilte_pkg::IDX_W;
    localparam int CNT_W  = ilte_pkg::CNT_W;
    localparam int CAP    = ilte_pkg::CAPACITY;

    // controller states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_FIND  = 2'd2;

    // request fields
    logic [3:0]        w_func;
    logic [CNT_W-1:0]  w_pos;
    logic [IDX_W-1:0]  w_last;
    logic [CNT_W-1:0]  w_newlen;
    logic [ELEM_W-1:0] w_val;

    assign w_func   = s_axis_tuser;
    assign w_pos    = s_axis_tdata[6:0];
    assign w_last   = s_axis_tdata[12:7];
    assign w_newlen = s_axis_tdata[19:13];
    assign w_val    = s_axis_tdata[51:20];

    // control registers
    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_pos,   n_pos;
    logic [IDX_W-1:0] r_rem,   n_rem;
    logic             r_is_del, n_is_del;

    // result register
    logic              r_m_valid;
    logic [ELEM_W-1:0] r_o_data;
    logic [6:0]        r_o_match;
    logic [CNT_W-1:0]  r_o_len;
    logic [2:0]        r_o_status;

    logic              w_in_acc;
    logic              w_emit;
    logic [ELEM_W-1:0] w_o_data;
    logic [6:0]        w_o_match;
    logic [2:0]        w_o_status;

    ilte_pkg::t_cell_cmd w_cmd;

    // cell chain
    logic [ELEM_W-1:0] w_cell_data [CAP];
    logic [CAP-1:0]    w_hits;
    logic              w_found;
    logic [IDX_W-1:0]  w_hit_idx;
    logic [IDX_W-1:0]  w_rd_idx;
    logic [ELEM_W-1:0] w_rd_data;
    logic [IDX_W-1:0]  w_span;

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic [ELEM_W-1:0] w_lower;
        logic [ELEM_W-1:0] w_upper;
        if (g == 0) begin : g_bottom
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_cell_data[g-1];
        end
        if (g == CAP - 1) begin : g_top
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_cell_data[g+1];
        end
        ilte_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_cmd        (w_cmd),
            .i_from_lower (w_lower),
            .i_from_upper (w_upper),
            .o_data       (w_cell_data[g]),
            .o_hit        (w_hits[g])
        );
    end

    ilte_prio u_prio (
        .i_hits  (w_hits),
        .o_found (w_found),
        .o_index (w_hit_idx)
    );

    // one read port: pop reads the top entry, read takes the requested slot
    assign w_rd_idx  = (w_func == ilte_pkg::FN_POP) ? IDX_W'(r_count - CNT_W'(1))
                                                     : w_pos[IDX_W-1:0];
    assign w_rd_data = w_cell_data[w_rd_idx];
    assign w_span    = w_last - w_pos[IDX_W-1:0];

    assign s_axis_tready = (r_state == S_IDLE) && (!r_m_valid || m_axis_tready);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_cmd      = '{op: ilte_pkg::CELL_HOLD, pos: '0, lim: r_count, value: w_val};
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_rem      = r_rem;
        n_is_del   = r_is_del;
        w_emit     = 1'b0;
        w_o_data   = '0;
        w_o_match  = ilte_pkg::NONE_POS;
        w_o_status = ilte_pkg::STS_OK;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_emit = 1'b1;
                    unique case (w_func) inside
                        ilte_pkg::FN_PUSH: begin
                            if (r_count >= ilte_pkg::CAP_CNT) begin
                                w_o_status = ilte_pkg::STS_FULL;
                            end else begin
                                w_cmd.op  = ilte_pkg::CELL_PUT;
                                w_cmd.pos = r_count;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        ilte_pkg::FN_POP: begin
                            if (r_count == '0) begin
                                w_o_status = ilte_pkg::STS_EMPTY;
                            end else begin
                                n_count  = r_count - CNT_W'(1);
                                w_o_data = w_rd_data;
                            end
                        end
                        ilte_pkg::FN_READ: begin
                            if (w_pos >= r_count) w_o_status = ilte_pkg::STS_RANGE;
                            else                  w_o_data   = w_rd_data;
                        end
                        ilte_pkg::FN_WRITE: begin
                            if (w_pos >= r_count) begin
                                w_o_status = ilte_pkg::STS_RANGE;
                            end else begin
                                w_cmd.op  = ilte_pkg::CELL_PUT;
                                w_cmd.pos = w_pos;
                            end
                        end
                        ilte_pkg::FN_INSERT: begin
                            if (r_count >= ilte_pkg::CAP_CNT) begin
                                w_o_status = ilte_pkg::STS_FULL;
                            end else if (w_pos > r_count) begin
                                w_o_status = ilte_pkg::STS_RANGE;
                            end else begin
                                w_cmd.op  = ilte_pkg::CELL_INSERT;
                                w_cmd.pos = w_pos;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        ilte_pkg::FN_DELETE: begin
                            if (w_pos >= r_count) begin
                                w_o_status = ilte_pkg::STS_RANGE;
                            end else begin
                                w_cmd.op  = ilte_pkg::CELL_REMOVE;
                                w_cmd.pos = w_pos;
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        ilte_pkg::FN_DELRNG: begin
                            if (w_pos > {1'b0, w_last} || {1'b0, w_last} >= r_count) begin
                                w_o_status = ilte_pkg::STS_RANGE;
                            end else begin
                                // first slot now, the rest one per cycle
                                w_cmd.op  = ilte_pkg::CELL_REMOVE;
                                w_cmd.pos = w_pos;
                                n_count   = r_count - CNT_W'(1);
                                n_pos     = w_pos;
                                n_rem     = w_span;
                                if (w_span != '0) begin
                                    w_emit  = 1'b0;
                                    n_state = S_SHIFT;
                                end
                            end
                        end
                        ilte_pkg::FN_DELVAL, ilte_pkg::FN_SEARCH: begin
                            w_cmd.op = ilte_pkg::CELL_CMP;
                            w_emit   = 1'b0;
                            n_is_del = (w_func == ilte_pkg::FN_DELVAL);
                            n_state  = S_FIND;
                        end
                        ilte_pkg::FN_EXTEND: begin
                            if (w_newlen > ilte_pkg::CAP_CNT) begin
                                w_o_status = ilte_pkg::STS_FULL;
                            end else if (w_newlen < r_count) begin
                                w_o_status = ilte_pkg::STS_RANGE;
                            end else begin
                                w_cmd.op  = ilte_pkg::CELL_FILL;
                                w_cmd.pos = r_count;
                                w_cmd.lim = w_newlen;
                                n_count   = w_newlen;
                            end
                        end
                        ilte_pkg::FN_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                w_cmd.op  = ilte_pkg::CELL_REMOVE;
                w_cmd.pos = r_pos;
                n_count   = r_count - CNT_W'(1);
                n_rem     = r_rem - IDX_W'(1);
                if (r_rem == IDX_W'(1)) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FIND: begin
                w_emit  = 1'b1;
                n_state = S_IDLE;
                if (w_found) begin
                    w_o_match = 7'({1'b0, w_hit_idx});
                    if (r_is_del) begin
                        w_cmd.op  = ilte_pkg::CELL_REMOVE;
                        w_cmd.pos = {1'b0, w_hit_idx};
                        n_count   = r_count - CNT_W'(1);
                    end
                end else begin
                    w_o_status = ilte_pkg::STS_NOTFOUND;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_emit) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_rem    <= n_rem;
        r_is_del <= n_is_del;
        if (w_emit) begin
            r_o_data   <= w_o_data;
            r_o_match  <= w_o_match;
            r_o_len    <= n_count;
            r_o_status <= w_o_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_o_status, r_o_len, r_o_match, r_o_data};

    // count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ilte_pkg::CAP_CNT)
        else $error("held count above capacity");

    // count is only touched by an accepted request or a running multi-cycle one
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !w_in_acc) |=> $stable(r_count))
        else $error("count changed while idle");

    // a range delete in progress always has slots left to remove
    a_shift_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_rem != '0))
        else $error("shift state with nothing left");

    // an empty refusal reports an empty list
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_o_status == ilte_pkg::STS_EMPTY) |-> (r_o_len == '0))
        else $error("empty status with entries held");

    // a reported match position comes only with an ok status
    a_match_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_o_match != ilte_pkg::NONE_POS) |-> (r_o_status == ilte_pkg::STS_OK))
        else $error("match position with failing status");

endmodule

### rtl/core/ilte_cell.sv
// One storage cell of the list: holds an entry, shifts with its neighbors, compares.
module ilte_cell (
    input  logic                               i_clk,
    input  logic [ilte_pkg::IDX_W-1:0]         i_index,
    input  ilte_pkg::t_cell_cmd                i_cmd,
    input  logic [ilte_pkg::ELEM_W-1:0]        i_from_lower,
    input  logic [ilte_pkg::ELEM_W-1:0]        i_from_upper,
    output logic [ilte_pkg::ELEM_W-1:0]        o_data,
    output logic                               o_hit
);

    logic [ilte_pkg::ELEM_W-1:0] r_data;
    logic [ilte_pkg::ELEM_W-1:0] n_data;
    logic                        r_hit;
    logic [ilte_pkg::CNT_W-1:0]  w_idx;
    logic [ilte_pkg::CNT_W-1:0]  w_idx_up;

    assign w_idx    = {1'b0, i_index};
    assign w_idx_up = w_idx + ilte_pkg::CNT_W'(1);

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            ilte_pkg::CELL_PUT: begin
                if (w_idx == i_cmd.pos) n_data = i_cmd.value;
            end
            ilte_pkg::CELL_INSERT: begin
                if (w_idx == i_cmd.pos) begin
                    n_data = i_cmd.value;
                end else if (w_idx > i_cmd.pos && w_idx <= i_cmd.lim) begin
                    n_data = i_from_lower;
                end
            end
            ilte_pkg::CELL_REMOVE: begin
                if (w_idx >= i_cmd.pos && w_idx_up < i_cmd.lim) n_data = i_from_upper;
            end
            ilte_pkg::CELL_FILL: begin
                if (w_idx >= i_cmd.pos && w_idx < i_cmd.lim) n_data = '0;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_cmd.op == ilte_pkg::CELL_CMP) begin
            r_hit <= (r_data == i_cmd.value) && (w_idx < i_cmd.lim);
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

### rtl/core/ilte_prio.sv
// Highest-set-bit encoder over the registered match flags of the cells.
module ilte_prio (
    input  logic [ilte_pkg::CAPACITY-1:0] i_hits,
    output logic                          o_found,
    output logic [ilte_pkg::IDX_W-1:0]    o_index
);

    always_comb begin
        o_index = '0;
        for (int k = 0; k < ilte_pkg::CAPACITY; k++) begin
            if (i_hits[k]) o_index = ilte_pkg::IDX_W'(k);
        end
    end

    assign o_found = |i_hits;

endmodule

### tb/sv/tb_indexed_list_table_engine.sv
// Self-checking testbench for the indexed list table engine: directed table, then random requests.
module tb_indexed_list_table_engine;
    import ilte_pkg::*;

    localparam int N_RANDOM     = 1120;
    localparam int QUIET_TAIL   = 150;   // last random requests run without any idling
    localparam int IDLE_CHUNK   = 150;   // idling pattern is re-rolled this often
    localparam int STALL_LIMIT  = 2000;  // cycles without any transfer before giving up
    localparam int DRAIN_CYCLES = 100;   // wait after the last result, longer than the longest range delete
    localparam int MAX_REPORTS  = 10;
    localparam int N_FUNC_SLOTS = 12;    // slots follow the request codes, last one is undefined

    localparam logic [3:0] FN_UNDEFINED = 4'hF;

    typedef struct packed {
        logic [3:0]  func;
        logic [6:0]  pos;
        logic [5:0]  last;
        logic [6:0]  new_len;
        logic [31:0] value;
    } t_list_req;

    typedef struct packed {
        logic [31:0] data;
        logic [6:0]  match_pos;
        logic [6:0]  len_now;
        logic [2:0]  status;
    } t_list_res;

    typedef struct packed {
        logic [3:0] func;
        t_list_res  res;
    } t_pending;

    typedef struct {
        t_list_req req;
        bit        fixed;   // expectation typed into the row instead of predicted
        t_list_res res;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [6:0] position, [12:7] range_last, [19:13] new_length, [51:20] operand_value, [55:52] zero
    logic [55:0] s_axis_tdata  = '0;
    // [3:0] func
    logic [3:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] data_out, [38:32] match_position, [45:39] length_now, [48:46] status, [55:49] zero
    logic [55:0] m_axis_tdata;

    indexed_list_table_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the list
    logic [31:0] list_mem [CAPACITY];
    int          list_len = 0;

    t_pending    pending_results [$];
    int          mismatches      = 0;
    int          quiet_cycles    = 0;
    bit          src_idle_en     = 1'b1;
    bit          sink_idle_en    = 1'b1;
    int          sink_stall_left = 0;

    // request mix while the list is growing (row 0) or shrinking (row 1)
    int func_weight [2][N_FUNC_SLOTS] = '{
        '{24, 6, 10, 8, 14, 6, 3, 6, 12, 5, 1, 2},
        '{10, 16, 8, 6, 6, 14, 8, 14, 10, 2, 2, 2}
    };

    function automatic int highest_match(logic [31:0] v);
        for (int i = list_len - 1; i >= 0; i--) begin
            if (list_mem[i] == v)
                return i;
        end
        return -1;
    endfunction

    function automatic void drop_span(int first, int n);
        for (int i = first; i + n < list_len; i++)
            list_mem[i] = list_mem[i + n];
        list_len -= n;
    endfunction

    // applies one request to the shadow list and returns the result it should produce
    function automatic t_list_res list_apply(t_list_req r);
        t_list_res res;
        int        hit;
        int        p;
        int        lst;
        int        nl;
        res.data      = '0;
        res.match_pos = NONE_POS;
        res.status    = STS_OK;
        p   = int'(r.pos);
        lst = int'(r.last);
        nl  = int'(r.new_len);
        case (r.func)
            FN_PUSH: begin
                if (list_len >= CAPACITY) begin
                    res.status = STS_FULL;
                end else begin
                    list_mem[list_len] = r.value;
                    list_len++;
                end
            end
            FN_POP: begin
                if (list_len == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    list_len--;
                    res.data = list_mem[list_len];
                end
            end
            FN_READ: begin
                if (p >= list_len) res.status = STS_RANGE;
                else res.data = list_mem[p];
            end
            FN_WRITE: begin
                if (p >= list_len) res.status = STS_RANGE;
                else list_mem[p] = r.value;
            end
            FN_INSERT: begin
                if (list_len >= CAPACITY) begin
                    res.status = STS_FULL;
                end else if (p > list_len) begin
                    res.status = STS_RANGE;
                end else begin
                    for (int i = list_len; i > p; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[p] = r.value;
                    list_len++;
                end
            end
            FN_DELETE: begin
                if (p >= list_len) res.status = STS_RANGE;
                else drop_span(p, 1);
            end
            FN_DELRNG: begin
                if (p > lst || lst >= list_len) res.status = STS_RANGE;
                else drop_span(p, lst - p + 1);
            end
            FN_DELVAL, FN_SEARCH: begin
                hit = highest_match(r.value);
                if (hit < 0) begin
                    res.status = STS_NOTFOUND;
                end else begin
                    res.match_pos = 7'(hit);
                    if (r.func == FN_DELVAL)
                        drop_span(hit, 1);
                end
            end
            FN_EXTEND: begin
                if (nl > CAPACITY) begin
                    res.status = STS_FULL;
                end else if (nl < list_len) begin
                    res.status = STS_RANGE;
                end else begin
                    for (int i = list_len; i < nl; i++)
                        list_mem[i] = '0;
                    list_len = nl;
                end
            end
            FN_CLEAR: list_len = 0;
            default: ;
        endcase
        res.len_now = 7'(list_len);
        return res;
    endfunction

    // fixed_len < 0: expectation comes from the predictor; otherwise data 0, no match
    function automatic t_dir_row dir_row(logic [3:0] func, int pos, int last, int new_len,
                                         logic [31:0] value, int fixed_len = -1,
                                         logic [2:0] fixed_status = STS_OK);
        t_dir_row row;
        row.req.func      = func;
        row.req.pos       = 7'(pos);
        row.req.last      = 6'(last);
        row.req.new_len   = 7'(new_len);
        row.req.value     = value;
        row.fixed         = (fixed_len >= 0);
        row.res.data      = '0;
        row.res.match_pos = NONE_POS;
        row.res.len_now   = 7'(fixed_len);
        row.res.status    = fixed_status;
        return row;
    endfunction

    // random request shaped by the current list length; mostly legal positions
    function automatic t_list_req random_request(bit grow);
        t_list_req r;
        int        roll;
        int        total;
        int        k;
        int        top;
        int        hi;
        total = 0;
        for (int i = 0; i < N_FUNC_SLOTS; i++)
            total += func_weight[grow ? 0 : 1][i];
        roll = $urandom_range(0, total - 1);
        k = 0;
        while (roll >= func_weight[grow ? 0 : 1][k]) begin
            roll -= func_weight[grow ? 0 : 1][k];
            k++;
        end
        if (k == N_FUNC_SLOTS - 1)
            r.func = 4'($urandom_range(int'(FN_CLEAR) + 1, int'(FN_UNDEFINED)));
        else
            r.func = 4'(k);

        // unused fields still carry random bits
        r.pos     = 7'($urandom);
        r.last    = 6'($urandom);
        r.new_len = 7'($urandom);
        case ($urandom_range(0, 5))
            0:       r.value = '1;
            1, 2:    r.value = 32'($urandom_range(0, 7));
            default: r.value = $urandom;
        endcase

        top = (list_len > 0) ? list_len - 1 : 0;
        case (r.func)
            FN_READ, FN_WRITE, FN_DELETE: begin
                if ($urandom_range(0, 9) != 0)
                    r.pos = 7'($urandom_range(0, top));
            end
            FN_INSERT: begin
                if ($urandom_range(0, 9) != 0)
                    r.pos = 7'($urandom_range(0, list_len));
            end
            FN_DELRNG: begin
                if ($urandom_range(0, 9) != 0) begin
                    if ($urandom_range(0, 24) == 0) begin
                        // whole list at once: slowest case, kept rare
                        r.pos  = '0;
                        r.last = 6'(top);
                    end else begin
                        r.pos = 7'($urandom_range(0, top));
                        hi = int'(r.pos) + $urandom_range(0, 3);
                        r.last = 6'((hi > 63) ? 63 : hi);
                    end
                end
            end
            FN_EXTEND: begin
                if ($urandom_range(0, 4) != 0) begin
                    hi = (list_len + 8 > CAPACITY) ? CAPACITY : list_len + 8;
                    r.new_len = 7'($urandom_range(list_len, hi));
                end
            end
            FN_SEARCH, FN_DELVAL: begin
                if (list_len > 0 && $urandom_range(0, 4) < 3)
                    r.value = list_mem[$urandom_range(0, list_len - 1)];
            end
            default: ;
        endcase
        return r;
    endfunction

    // one request transfer; the expectation is queued at the accepting edge
    task automatic send_request(t_list_req r, bit fixed, t_list_res fixed_res);
        int       gap;
        t_pending exp_item;
        gap = 0;
        if (src_idle_en && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.func;
        s_axis_tdata  <= {4'b0, r.value, r.new_len, r.last, r.pos};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        exp_item.func = r.func;
        exp_item.res  = list_apply(r);
        if (fixed)
            exp_item.res = fixed_res;
        pending_results.push_back(exp_item);
    endtask

    // result sink with bursty back-pressure
    always @(negedge i_clk) begin
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
            sink_stall_left = $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_list_res got;
        t_pending  exp_item;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                got.data      = m_axis_tdata[31:0];
                got.match_pos = m_axis_tdata[38:32];
                got.len_now   = m_axis_tdata[45:39];
                got.status    = m_axis_tdata[48:46];
                if (pending_results.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result: data %h match %h len %0d status %0d",
                                 got.data, got.match_pos, got.len_now, got.status);
                    mismatches++;
                end else begin
                    exp_item = pending_results.pop_front();
                    if (got !== exp_item.res) begin
                        if (mismatches < MAX_REPORTS)
                            $display("mismatch on func %0d: expected data %h match %h len %0d ",
                                     exp_item.func, exp_item.res.data, exp_item.res.match_pos,
                                     exp_item.res.len_now,
                                     "status %0d, got data %h match %h len %0d status %0d",
                                     exp_item.res.status, got.data, got.match_pos,
                                     got.len_now, got.status);
                        mismatches++;
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("indexed_list_table_engine test failed");
                $finish;
            end
        end
    end

    initial begin
        t_dir_row  rows [$];
        t_list_res no_res;
        bit        grow;
        no_res = '0;
        grow   = 1'b1;

        // requests on the empty list, mostly refusals
        rows.push_back(dir_row(FN_POP,    0,  0,  0, '0, 0, STS_EMPTY));
        rows.push_back(dir_row(FN_READ,   0,  0,  0, '0, 0, STS_RANGE));
        rows.push_back(dir_row(FN_DELETE, 0,  0,  0, '0, 0, STS_RANGE));
        rows.push_back(dir_row(FN_DELRNG, 0,  0,  0, '0, 0, STS_RANGE));
        rows.push_back(dir_row(FN_SEARCH, 0,  0,  0, '0, 0, STS_NOTFOUND));
        rows.push_back(dir_row(FN_DELVAL, 0,  0,  0, '1, 0, STS_NOTFOUND));
        rows.push_back(dir_row(FN_EXTEND, 0,  0,  0, '0, 0, STS_OK));
        rows.push_back(dir_row(FN_EXTEND, 0,  0, 65, '0, 0, STS_FULL));
        // build a short list and poke at its edges
        rows.push_back(dir_row(FN_PUSH,   0,  0,  0, '1, 1, STS_OK));
        rows.push_back(dir_row(FN_PUSH,   0,  0,  0, '0, 2, STS_OK));
        rows.push_back(dir_row(FN_INSERT, 3,  0,  0, '1, 2, STS_RANGE));
        rows.push_back(dir_row(FN_INSERT, 2,  0,  0, 32'd5));
        rows.push_back(dir_row(FN_INSERT, 0,  0,  0, 32'hA5A5_A5A5));
        rows.push_back(dir_row(FN_READ,   127, 63, 127, '1, 4, STS_RANGE));
        rows.push_back(dir_row(FN_SEARCH, 0,  0,  0, '1));
        rows.push_back(dir_row(FN_WRITE,  3,  0,  0, '0));
        rows.push_back(dir_row(FN_DELRNG, 2,  1,  0, '0, 4, STS_RANGE));
        rows.push_back(dir_row(FN_DELRNG, 0, 63,  0, '0, 4, STS_RANGE));
        rows.push_back(dir_row(FN_DELVAL, 0,  0,  0, '0));
        rows.push_back(dir_row(FN_DELETE, 0,  0,  0, '0));
        rows.push_back(dir_row(FN_POP,    0,  0,  0, '0));
        // fill by extension, the full-list refusals, then empty it and finish with a clear
        rows.push_back(dir_row(FN_EXTEND, 0,  0, 64, '0, 64, STS_OK));
        rows.push_back(dir_row(FN_PUSH,   0,  0,  0, '1, 64, STS_FULL));
        rows.push_back(dir_row(FN_INSERT, 127, 0, 0, '1, 64, STS_FULL));
        rows.push_back(dir_row(FN_EXTEND, 0,  0, 10, '0, 64, STS_RANGE));
        rows.push_back(dir_row(FN_READ,   63, 0,  0, '0));
        rows.push_back(dir_row(FN_DELRNG, 0, 63,  0, '0, 0, STS_OK));
        rows.push_back(dir_row(FN_UNDEFINED, 0, 0, 0, '1, 0, STS_OK));
        rows.push_back(dir_row(FN_PUSH,   0,  0,  0, 32'd7));
        rows.push_back(dir_row(FN_CLEAR,  0,  0,  0, '0, 0, STS_OK));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i])
            send_request(rows[i].req, rows[i].fixed, rows[i].res);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % IDLE_CHUNK == 0) begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (n >= N_RANDOM - QUIET_TAIL) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            // grow until full (lingering there a little), then drain to near empty
            if (list_len == CAPACITY && $urandom_range(0, 3) == 0)
                grow = 1'b0;
            if (list_len <= 2)
                grow = 1'b1;
            send_request(random_request(grow), 1'b0, no_res);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("indexed_list_table_engine test passed");
        else
            $display("indexed_list_table_engine test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/ilte_pkg.sv
rtl/core/ilte_cell.sv
rtl/core/ilte_prio.sv
rtl/core/indexed_list_table_engine.sv
tb/sv/tb_indexed_list_table_engine.sv
